@@ rtl/klisr_pkg.sv @@
// Shared constants for the key list insert, search and remove core.
package klisr_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int KEY_W    = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    match_count;
    logic [CNT_W-1:0]    entry_count;
  } result_t;

endpackage

@@ rtl/klisr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module klisr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/klisr_ctrl.sv @@
// Sequencer and shared key comparator for the key list over a ring-addressed RAM.
module klisr_ctrl import klisr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    key,
  output logic                busy,
  output logic                done,
  output result_t             result,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [KEY_W-1:0]    ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [KEY_W-1:0]    ram_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SWR  = 3'd4;

  logic [2:0]          state, state_next;
  logic [AW-1:0]       idx, idx_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       hits, hits_next;
  logic [ACTION_W-1:0] act, act_next;
  logic [KEY_W-1:0]    key_r, key_next;
  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  logic [AW-1:0]       head_m1;
  logic [AW-1:0]       idx_m1;
  logic                last;
  logic                hit;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, i};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat(input logic [CW-1:0] v);
    return (32'(v) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(v);
  endfunction

  assign head_m1   = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign idx_m1    = idx - AW'(1);
  assign last      = (CW'(idx) + CW'(1)) == count;
  assign hit       = ram_rdata == key_r;
  assign busy      = state != S_IDLE;
  assign ram_raddr = phys(head, idx);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    head_next    = head;
    count_next   = count;
    hits_next    = hits;
    act_next     = act;
    key_next     = key_r;
    fin          = 1'b0;
    fin_status   = ST_DONE;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = phys(head, idx_m1);
    ram_wdata    = ram_rdata;
    case (state)
      S_IDLE: begin
        if (start) begin
          act_next     = action;
          key_next     = key;
          hits_next    = '0;
          idx_next     = '0;
          case (action)
            ACT_INSERT: begin
              fin = 1'b1;
              if (count == CW'(DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = head_m1;
                ram_wdata  = key;
                head_next  = head_m1;
                count_next = count + CW'(1);
              end
            end
            ACT_SEARCH: begin
              if (count == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                state_next = S_RD;
              end
            end
            ACT_REMOVE: begin
              if (count == '0) begin
                fin        = 1'b1;
                fin_status = ST_NOT_FOUND;
              end else begin
                state_next = S_RD;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        ram_re     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (act == ACT_SEARCH) begin
          if (hit) begin
            hits_next = hits + CW'(1);
          end
          if (last) begin
            fin        = 1'b1;
            fin_status = (hits_next == '0) ? ST_NOT_FOUND : ST_DONE;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_RD;
          end
        end else if (hit) begin
          if (last) begin
            count_next = count - CW'(1);
            fin        = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_SRD;
          end
        end else if (last) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_RD;
        end
      end
      S_SRD: begin
        ram_re     = 1'b1;
        state_next = S_SWR;
      end
      S_SWR: begin
        ram_we = 1'b1;
        if (last) begin
          count_next = count - CW'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      hits  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      hits  <= hits_next;
      done  <= fin;
    end
    idx   <= idx_next;
    act   <= act_next;
    key_r <= key_next;
    if (fin) begin
      result.status      <= fin_status;
      result.match_count <= sat(hits_next);
      result.entry_count <= sat(count_next);
    end
  end

endmodule

@@ rtl/key_list_insert_search_remove_core.sv @@
// Top level of the key list core: sequencer, key RAM and result ports.
//
// Keeps up to DEPTH signed 32-bit keys, newest first. A request beat
// (action, key) is taken at a rising edge with start high and busy low.
// Insert puts the key at the front unless the list is full, search counts
// equal keys, remove deletes the newest equal key and closes the gap.
// Each request yields one result beat: done is high for exactly one cycle
// with status, match_count and entry_count. The receiver cannot stall;
// a result must be taken in that cycle.
// Insert, no-op and requests on an empty list register done in the
// cycle after accept. Search walks the list through the single RAM read
// port and the shared comparator, reading and then comparing each entry.
// Remove reads and compares each entry up to the match, then reads each
// older entry and writes it back one place nearer the front.
// busy stays high over the walk; a new request may be accepted in the
// cycle the previous result is shown.
// Reset empties the list at once; RAM contents are not cleared.
module key_list_insert_search_remove_core import klisr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [ACTION_W-1:0]        action,
  input  logic signed [KEY_W-1:0]    key,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [CNT_W-1:0]           match_count,
  output logic [CNT_W-1:0]           entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t          result;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  klisr_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .key       (key),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  klisr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status      = result.status;
  assign match_count = result.match_count;
  assign entry_count = result.entry_count;

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty status with nonzero entry count");

  a_match_status: assert property (@(posedge clk) disable iff (rst)
    done && match_count != '0 |-> status == ST_DONE)
    else $error("matches reported without done status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> 32'(entry_count) == ((DEPTH > 31) ? 31 : DEPTH))
    else $error("full status with list not full");

endmodule

@@ test/testbench.sv @@
// Testbench for the key list core: checks every result beat against a shadow list.
`timescale 1ns / 100ps

module testbench;
  import klisr_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_TAIL = 200;
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
  } request_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [ACTION_W-1:0]     action = ACT_INSERT;
  logic signed [KEY_W-1:0] key = '0;
  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [CNT_W-1:0]        match_count;
  logic [CNT_W-1:0]        entry_count;

  request_t         req_queue[$];
  result_t          pending_results[$];
  logic [KEY_W-1:0] list_keys[$];
  logic             taken = 1'b0;
  int               idle_left = 0;
  int               errors = 0;
  int               cycles = 0;
  int               checked = 0;
  int               seen_act[4] = '{default: 0};
  int               seen_status[4] = '{default: 0};

  key_list_insert_search_remove_core #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .key        (key),
    .done       (done),
    .status     (status),
    .match_count(match_count),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_count(input int n);
    return (n > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(n);
  endfunction

  function automatic result_t apply_request(input logic [ACTION_W-1:0] act,
                                            input logic [KEY_W-1:0] k);
    result_t r;
    int      hits;
    int      pos;
    r.status = ST_DONE;
    hits = 0;
    pos = -1;
    case (act)
      ACT_INSERT: begin
        if (list_keys.size() >= DEPTH) r.status = ST_FULL;
        else list_keys.push_front(k);
      end
      ACT_SEARCH: begin
        if (list_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (list_keys[i]) if (list_keys[i] == k) hits++;
          r.status = (hits == 0) ? ST_NOT_FOUND : ST_DONE;
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < list_keys.size(); i++)
          if (pos < 0 && list_keys[i] == k) pos = i;
        if (pos < 0) r.status = ST_NOT_FOUND;
        else list_keys.delete(pos);
      end
      default: ;
    endcase
    r.match_count = sat_count(hits);
    r.entry_count = sat_count(list_keys.size());
    return r;
  endfunction

  task automatic add_req(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    request_t r;
    r.action = act;
    r.key = k;
    req_queue.push_back(r);
  endtask

  // stimulus
  initial begin
    logic [KEY_W-1:0]    pool[6];
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    k;
    int                  phase_left;
    int                  ins_w;
    int                  roll;

    add_req(ACT_SEARCH, 32'd5);
    add_req(ACT_REMOVE, 32'd5);
    add_req(ACT_NOP, 32'hffff_ffff);
    add_req(ACT_INSERT, 32'h8000_0000);
    add_req(ACT_INSERT, 32'h7fff_ffff);
    add_req(ACT_INSERT, 32'h0000_0000);
    add_req(ACT_INSERT, 32'hffff_ffff);
    add_req(ACT_INSERT, 32'h7fff_ffff);
    add_req(ACT_SEARCH, 32'h7fff_ffff);
    add_req(ACT_SEARCH, 32'd7);
    add_req(ACT_REMOVE, 32'h7fff_ffff);
    add_req(ACT_REMOVE, 32'h8000_0000);
    add_req(ACT_REMOVE, 32'd12345);
    for (int i = 0; i < DEPTH - 3; i++) add_req(ACT_INSERT, 32'(i * 3));
    add_req(ACT_INSERT, 32'h5555_aaaa);
    add_req(ACT_SEARCH, 32'hffff_ffff);
    add_req(ACT_REMOVE, 32'h7fff_ffff);

    // phases lean toward filling or draining; small key pools force hits
    phase_left = 0;
    ins_w = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        ins_w = $urandom_range(15, 75);
        foreach (pool[j]) pool[j] = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          pool[0] = 32'h8000_0000;
          pool[1] = 32'h7fff_ffff;
          pool[2] = 32'h0000_0000;
        end
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) act = ACT_NOP;
      else if (roll < 2 + ins_w) act = ACT_INSERT;
      else if (roll < 2 + ins_w + (98 - ins_w) / 2) act = ACT_SEARCH;
      else act = ACT_REMOVE;
      k = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 5)];
      add_req(act, k);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // driver: present one beat at a time, hold it until accepted
  always @(negedge clk) begin
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (!start || taken) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (req_queue.size() != 0) begin
        nxt = req_queue.pop_front();
        action <= nxt.action;
        key <= nxt.key;
        start <= 1'b1;
        if (req_queue.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
          idle_left <= $urandom_range(1, 13);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result beats, predict on accepted requests
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        got.status = status;
        got.match_count = match_count;
        got.entry_count = entry_count;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %p", $time, got);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
          if (got.match_count !== want.match_count) begin
            errors++;
            $display("%0t: match_count expected %0d got %0d", $time,
                     want.match_count, got.match_count);
          end
          if (got.entry_count !== want.entry_count) begin
            errors++;
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
          end
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        want = apply_request(action, key);
        pending_results.push_back(want);
        seen_act[action]++;
        seen_status[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    @(negedge clk);
    while (rst || req_queue.size() != 0 || start || pending_results.size() != 0)
      @(negedge clk);
    repeat (2 * DEPTH + 4) @(negedge clk);
    $display("%0d results checked: %0d insert, %0d search, %0d remove, %0d no-op",
             checked, seen_act[ACT_INSERT], seen_act[ACT_SEARCH], seen_act[ACT_REMOVE],
             seen_act[ACT_NOP]);
    $display("list full on insert %0d times, empty search %0d times, key missing %0d times",
             seen_status[ST_FULL], seen_status[ST_EMPTY], seen_status[ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
